// File: src/pfe_pkg.sv
// ----------------------------------------------------------------------------
// pfe_pkg: shared types and codes of the programmable state machine engine
// Operation codes, result status codes, field widths and the result word.
// ----------------------------------------------------------------------------
package pfe_pkg;

	localparam int FUNC_W  = 2;
	localparam int STATE_W = 4;
	localparam int EVENT_W = 8;
	localparam int STAT_W  = 3;

	// Operation codes
	localparam logic [FUNC_W-1:0] FN_ADD_LINK   = 2'd0;
	localparam logic [FUNC_W-1:0] FN_SET_STATE  = 2'd1;
	localparam logic [FUNC_W-1:0] FN_SET_NOTIFY = 2'd2;
	localparam logic [FUNC_W-1:0] FN_PUSH_EVENT = 2'd3;

	// Result status codes
	localparam logic [STAT_W-1:0] ST_DONE     = 3'd0;
	localparam logic [STAT_W-1:0] ST_NOTIFIED = 3'd1;
	localparam logic [STAT_W-1:0] ST_NO_MATCH = 3'd2;
	localparam logic [STAT_W-1:0] ST_NO_STATE = 3'd3;
	localparam logic [STAT_W-1:0] ST_FULL     = 3'd4;

	typedef logic [STATE_W-1:0] state_idx_t;
	typedef logic [EVENT_W-1:0] event_t;

	// One stored link: destination above event
	typedef struct packed {
		state_idx_t target;
		event_t     evt;
	} link_t;

	// One result word
	typedef struct packed {
		logic [STAT_W-1:0] status;
		state_idx_t        prev_state;
		event_t            event_out;
		state_idx_t        new_state;
	} result_t;

endpackage

// File: src/pfe_ram.sv
// ----------------------------------------------------------------------------
// pfe_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module pfe_ram #(
	parameter int WIDTH = 12,
	parameter int DEPTH = 128
) (
	input  logic                                   clk,
	input  logic                                   wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                       wr_data,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                       rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

// File: src/programmable_fsm_engine_top.sv
// ----------------------------------------------------------------------------
// programmable_fsm_engine_top: table-driven programmable state machine
// Link lists per state in a RAM, scanned one link per cycle on each event.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_*: one word per operation. s_tuser carries the operation
//   code (add link, set current state, set notify flag, push event) and
//   s_tdata its operands. Output channel m_*: exactly one result word per
//   operation, in order; m_tuser carries the status, m_tdata the states and
//   the pushed event.
//   Timing: a word is taken only while the engine is idle. Add link, set
//   state and set notify pass from the execute state to the emit state,
//   where the result is handed to the output register. Push event scans
//   the links of the current state in between, up to and including the
//   first match (at most MAX_LINKS); the link RAM returns one link per
//   cycle, with its read data registered in the RAM itself.
//   The result sits in an output register; while the receiver stalls, the
//   engine still accepts and works on the next word and only waits at the
//   point where it must hand its result over.
//   Reset (arst_n low) clears all link counts, notify flags and the
//   current state; the link RAM itself is not cleared, since only entries
//   below a state's count are ever used.
// ----------------------------------------------------------------------------
module programmable_fsm_engine_top #(
	parameter int NUM_STATES = 16,
	parameter int MAX_LINKS  = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	// s_tdata: src_state[3:0], event_code[11:4], target_state[15:12],
	//          notify_on[16], zero padding[23:17]
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,
	input  logic [1:0]  s_tuser,   // func[1:0]
	// m_tdata: prev_state[3:0], event_out[11:4], new_state[15:12]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,
	output logic [2:0]  m_tuser    // status[2:0]
);

	// States beyond the 4-bit field can never be named, so hold no storage
	localparam int NS_USED = (NUM_STATES < 16) ? NUM_STATES : 16;
	localparam int SIW     = $clog2(NS_USED);
	localparam int LW      = (MAX_LINKS > 1) ? $clog2(MAX_LINKS) : 1;
	localparam int CW      = $clog2(MAX_LINKS + 1);
	localparam int RAM_D   = NS_USED << LW;
	localparam int RAM_AW  = SIW + LW;
	localparam int LINK_W  = $bits(pfe_pkg::link_t);
	localparam logic [8:0]    NS_LIM  = 9'(NUM_STATES);
	localparam logic [CW-1:0] CNT_MAX = CW'(MAX_LINKS);

	// Sequencer codes
	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_SCAN = 2'd2;
	localparam logic [1:0] S_EMIT = 2'd3;

	logic [1:0] state_q;

	// Captured operation
	logic [pfe_pkg::FUNC_W-1:0] func_q;
	pfe_pkg::state_idx_t        src_q;
	pfe_pkg::event_t            ev_q;
	pfe_pkg::state_idx_t        dst_q;
	logic                       nflag_q;

	// Engine state held in flops
	logic [CW-1:0]       count_q [NS_USED];
	logic                notify_q [NS_USED];
	pfe_pkg::state_idx_t cur_q;
	logic                cur_vld_q;

	// Scan position and pending result
	logic [LW-1:0]     idx_q;
	pfe_pkg::result_t  res_q;
	pfe_pkg::result_t  res_init;

	// Output register
	logic              out_vld_q;
	pfe_pkg::result_t  out_q;

	logic                ram_we;
	logic [RAM_AW-1:0]   ram_waddr;
	logic [RAM_AW-1:0]   ram_raddr;
	pfe_pkg::link_t      ram_wdata;
	logic [LINK_W-1:0]   ram_rdata;
	pfe_pkg::link_t      rd_link;

	logic                src_ok;
	logic                dst_ok;
	logic                tgt_ok;
	logic [CW-1:0]       src_cnt;
	logic [CW-1:0]       cur_cnt;
	logic [CW-1:0]       idx_next;
	logic                out_free;
	logic [LW-1:0]       idx_inc;

	assign s_tready = (state_q == S_IDLE);
	assign out_free = !out_vld_q || m_tready;

	assign src_ok   = ({5'd0, src_q} < NS_LIM);
	assign dst_ok   = ({5'd0, dst_q} < NS_LIM);
	assign src_cnt  = count_q[src_q[SIW-1:0]];
	assign cur_cnt  = count_q[cur_q[SIW-1:0]];
	assign idx_next = CW'(idx_q) + CW'(1);
	assign idx_inc  = idx_q + LW'(1);

	assign rd_link  = pfe_pkg::link_t'(ram_rdata);
	assign tgt_ok   = ({5'd0, rd_link.target} < NS_LIM);

	// Append at the end of the source state's list
	assign ram_we          = (state_q == S_EXEC) && (func_q == pfe_pkg::FN_ADD_LINK)
	                         && src_ok && dst_ok && (src_cnt != CNT_MAX);
	assign ram_waddr       = {src_q[SIW-1:0], src_cnt[LW-1:0]};
	assign ram_wdata.target = dst_q;
	assign ram_wdata.evt    = ev_q;

	// First link on entry to the scan, then the one after the link in hand
	assign ram_raddr = (state_q == S_EXEC) ? {cur_q[SIW-1:0], {LW{1'b0}}}
	                                      : {cur_q[SIW-1:0], idx_inc};

	pfe_ram #(
		.WIDTH(LINK_W),
		.DEPTH(RAM_D)
	) u_link_ram (
		.clk    (clk),
		.wr_en  (ram_we),
		.wr_addr(ram_waddr),
		.wr_data(ram_wdata),
		.rd_addr(ram_raddr),
		.rd_data(ram_rdata)
	);

	// Payload capture
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			func_q  <= s_tuser;
			src_q   <= s_tdata[3:0];
			ev_q    <= s_tdata[11:4];
			dst_q   <= s_tdata[15:12];
			nflag_q <= s_tdata[16];
		end
	end

	// Sequencer and engine state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cur_q     <= '0;
			cur_vld_q <= 1'b0;
			idx_q     <= '0;
			for (int i = 0; i < NS_USED; i++) begin
				count_q[i]  <= '0;
				notify_q[i] <= 1'b0;
			end
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					// Scan only when there is a list to look at
					if ((func_q == pfe_pkg::FN_PUSH_EVENT) && cur_vld_q
					    && (cur_cnt != '0)) begin
						state_q <= S_SCAN;
						idx_q   <= '0;
					end else begin
						state_q <= S_EMIT;
					end
					unique case (func_q)
						pfe_pkg::FN_ADD_LINK: begin
							if (ram_we) begin
								count_q[src_q[SIW-1:0]] <= src_cnt + CW'(1);
							end
						end
						pfe_pkg::FN_SET_STATE: begin
							if (src_ok) begin
								cur_q     <= src_q;
								cur_vld_q <= 1'b1;
							end
						end
						pfe_pkg::FN_SET_NOTIFY: begin
							if (src_ok) begin
								notify_q[src_q[SIW-1:0]] <= nflag_q;
							end
						end
						pfe_pkg::FN_PUSH_EVENT: ;
						default: ;
					endcase
				end
				S_SCAN: begin
					if (rd_link.evt == ev_q) begin
						state_q <= S_EMIT;
						if (tgt_ok) begin
							cur_q <= rd_link.target;
						end
					end else if (idx_next < cur_cnt) begin
						idx_q <= idx_inc;
					end else begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Result before any scan
	always_comb begin
		res_init = '0;
		if (func_q == pfe_pkg::FN_ADD_LINK) begin
			if (src_ok && dst_ok && (src_cnt == CNT_MAX)) begin
				res_init.status = pfe_pkg::ST_FULL;
			end
		end else if (func_q == pfe_pkg::FN_PUSH_EVENT) begin
			res_init.event_out = ev_q;
			if (!cur_vld_q) begin
				res_init.status = pfe_pkg::ST_NO_STATE;
			end else begin
				// Empty list reports no match right away
				res_init.status     = pfe_pkg::ST_NO_MATCH;
				res_init.prev_state = cur_q;
				res_init.new_state  = cur_q;
			end
		end
	end

	// Pending result
	always_ff @(posedge clk) begin
		if (state_q == S_EXEC) begin
			res_q <= res_init;
		end else if (state_q == S_SCAN) begin
			if ((rd_link.evt == ev_q) && tgt_ok) begin
				res_q.status    <= notify_q[rd_link.target[SIW-1:0]]
				                   ? pfe_pkg::ST_NOTIFIED : pfe_pkg::ST_DONE;
				res_q.new_state <= rd_link.target;
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if ((state_q == S_EMIT) && out_free) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_EMIT) && out_free) begin
			out_q <= res_q;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tuser  = out_q.status;
	assign m_tdata  = {out_q.new_state, out_q.event_out, out_q.prev_state};

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for programmable_fsm_engine_top
// Drives operation words into the engine through its input stream and keeps
// a shadow copy of the link lists, notify flags and current state. Each
// accepted word is applied to that copy, which yields the result word the
// engine must return. Returned words are checked field by field in order.
// A directed sequence covers the corner cases, then random traffic runs
// under several idle and stall profiles.
// ----------------------------------------------------------------------------
module testbench;

	localparam int NUM_ST     = 16;
	localparam int MAX_LK     = 8;
	localparam int IDLE_LIMIT = 1000;  // cycles with no word moving on either side
	localparam int HOLD_LEN   = 80;    // long receiver hold-off
	localparam int TAIL_LEN   = 20;    // quiet cycles after the last result
	localparam int PHASE_LEN  = 185;

	// Shadow of the engine: link lists, flags and current state, plus the
	// queue of result words still owed by the engine.
	class fsm_shadow;
		pfe_pkg::event_t     link_evt [NUM_ST][MAX_LK];
		pfe_pkg::state_idx_t link_dst [NUM_ST][MAX_LK];
		int                  link_cnt [NUM_ST];
		bit                  notify   [NUM_ST];
		pfe_pkg::state_idx_t cur_st;
		bit                  cur_valid;
		pfe_pkg::result_t    expected_results[$];
		int                  mismatches;

		task report(string msg);
			$display("MISMATCH: %s", msg);
			mismatches++;
		endtask

		// Apply one accepted operation word and queue the result it owes.
		function void apply_op(logic [1:0] fn, logic [23:0] word);
			pfe_pkg::state_idx_t src;
			pfe_pkg::state_idx_t dst;
			pfe_pkg::event_t     evt;
			bit                  on;
			int                  hit;
			pfe_pkg::result_t    res;
			src = word[3:0];
			evt = word[11:4];
			dst = word[15:12];
			on  = word[16];
			res = '0;
			case (fn)
			pfe_pkg::FN_ADD_LINK: begin
				if (link_cnt[src] >= MAX_LK) begin
					res.status = pfe_pkg::ST_FULL;
				end else begin
					link_evt[src][link_cnt[src]] = evt;
					link_dst[src][link_cnt[src]] = dst;
					link_cnt[src]++;
				end
			end
			pfe_pkg::FN_SET_STATE: begin
				cur_st    = src;
				cur_valid = 1'b1;
			end
			pfe_pkg::FN_SET_NOTIFY: begin
				notify[src] = on;
			end
			pfe_pkg::FN_PUSH_EVENT: begin
				res.event_out = evt;
				if (!cur_valid) begin
					res.status = pfe_pkg::ST_NO_STATE;
				end else begin
					// first matching link in insertion order wins
					hit = -1;
					for (int i = 0; i < link_cnt[cur_st]; i++)
						if (hit < 0 && link_evt[cur_st][i] == evt)
							hit = i;
					res.prev_state = cur_st;
					res.new_state  = cur_st;
					res.status     = pfe_pkg::ST_NO_MATCH;
					if (hit >= 0) begin
						res.new_state = link_dst[cur_st][hit];
						res.status    = notify[res.new_state] ? pfe_pkg::ST_NOTIFIED
						                                      : pfe_pkg::ST_DONE;
						cur_st        = res.new_state;
					end
				end
			end
			endcase
			expected_results.push_back(res);
		endfunction

		// Compare one returned word with the oldest owed result.
		task check_result(logic [2:0] status, logic [15:0] data);
			pfe_pkg::result_t want;
			if (expected_results.size() == 0) begin
				report($sformatf("result word with nothing owed: status %0d data %h",
					status, data));
				return;
			end
			want = expected_results.pop_front();
			if (status !== want.status)
				report($sformatf("status got %0d want %0d", status, want.status));
			if (data[3:0] !== want.prev_state)
				report($sformatf("prev_state got %0d want %0d", data[3:0], want.prev_state));
			if (data[11:4] !== want.event_out)
				report($sformatf("event_out got %h want %h", data[11:4], want.event_out));
			if (data[15:12] !== want.new_state)
				report($sformatf("new_state got %0d want %0d", data[15:12], want.new_state));
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;
	logic [2:0]  m_tuser;

	fsm_shadow shadow;
	int        send_idle_pct;
	int        recv_stall_pct;
	int        hold_reqs;
	int        hold_done;
	int        quiet_cycles;

	programmable_fsm_engine_top #(
		.NUM_STATES(NUM_ST),
		.MAX_LINKS (MAX_LK)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// Pack operands, first field in the lowest bits.
	function automatic logic [23:0] pack_word(pfe_pkg::state_idx_t src,
			pfe_pkg::event_t evt, pfe_pkg::state_idx_t dst, bit on);
		return {7'd0, on, dst, evt, src};
	endfunction

	// Offer one word, idling first at the current rate; return once accepted.
	task automatic send_op(logic [1:0] fn, logic [23:0] word);
		while ($urandom_range(99) < send_idle_pct) begin
			@(negedge clk);
			s_tvalid = 1'b0;
		end
		@(negedge clk);
		s_tvalid = 1'b1;
		s_tuser  = fn;
		s_tdata  = word;
		do
			@(posedge clk);
		while (!s_tready);
		shadow.apply_op(fn, word);
	endtask

	// Hold until every owed result has come back.
	task automatic drain();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (shadow.expected_results.size() != 0)
			@(posedge clk);
	endtask

	// Random traffic, pushes the largest share and most aimed at stored links so
	// the machine walks through its states, mixed with link adds, state and flag updates.
	task automatic run_phase(int n_ops, int idle_pct, int stall_pct, bit with_hold);
		int                  pick;
		logic [1:0]          fn;
		pfe_pkg::state_idx_t src;
		pfe_pkg::state_idx_t dst;
		pfe_pkg::event_t     evt;
		pfe_pkg::state_idx_t cur;
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		for (int k = 0; k < n_ops; k++) begin
			if (with_hold && k == 60)
				hold_reqs++;
			pick = $urandom_range(99);
			src  = 4'($urandom);
			dst  = 4'($urandom);
			evt  = ($urandom_range(2) == 0) ? 8'($urandom) : 8'($urandom_range(15) * 17);
			cur  = shadow.cur_st;
			if (pick < 45) begin
				fn = pfe_pkg::FN_PUSH_EVENT;
				if (shadow.cur_valid && shadow.link_cnt[cur] > 0 && $urandom_range(3) != 0)
					evt = shadow.link_evt[cur][$urandom_range(shadow.link_cnt[cur] - 1)];
			end else if (pick < 75) begin
				fn = pfe_pkg::FN_ADD_LINK;
				if ($urandom_range(1) == 0)
					src = cur;
			end else if (pick < 88) begin
				fn = pfe_pkg::FN_SET_STATE;
			end else begin
				fn = pfe_pkg::FN_SET_NOTIFY;
			end
			send_op(fn, pack_word(src, evt, dst, 1'($urandom)));
		end
		drain();
	endtask

	// Receiver: check at the rising edge, pick ready at the falling edge.
	// A pending hold-off request parks ready low for a long stretch.
	initial begin
		m_tready  = 1'b0;
		hold_done = 0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready)
				shadow.check_result(m_tuser, m_tdata);
			@(negedge clk);
			if (hold_done != hold_reqs) begin
				m_tready = 1'b0;
				hold_done++;
				repeat (HOLD_LEN) @(negedge clk);
			end
			m_tready = ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Watchdog: end the run when nothing moves for too long.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		shadow         = new();
		arst_n         = 1'b0;
		s_tvalid       = 1'b0;
		s_tdata        = '0;
		s_tuser        = pfe_pkg::FN_ADD_LINK;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_reqs      = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: no current state yet, both event extremes
		send_op(pfe_pkg::FN_PUSH_EVENT, pack_word(4'd0, 8'h00, 4'd0, 1'b0));
		send_op(pfe_pkg::FN_PUSH_EVENT, pack_word(4'd15, 8'hFF, 4'd15, 1'b1));
		// notify flag on state 15, flag cleared on state 3
		send_op(pfe_pkg::FN_SET_NOTIFY, pack_word(4'd15, 8'h00, 4'd0, 1'b1));
		send_op(pfe_pkg::FN_SET_NOTIFY, pack_word(4'd3, 8'h00, 4'd0, 1'b0));
		// enter state 0 and push with an empty link list
		send_op(pfe_pkg::FN_SET_STATE, pack_word(4'd0, 8'h00, 4'd0, 1'b0));
		send_op(pfe_pkg::FN_PUSH_EVENT, pack_word(4'd0, 8'h5A, 4'd0, 1'b0));
		// duplicate event: the earlier link must win
		send_op(pfe_pkg::FN_ADD_LINK, pack_word(4'd0, 8'hFF, 4'd15, 1'b0));
		send_op(pfe_pkg::FN_ADD_LINK, pack_word(4'd0, 8'hFF, 4'd3, 1'b0));
		send_op(pfe_pkg::FN_ADD_LINK, pack_word(4'd0, 8'h00, 4'd0, 1'b0));
		send_op(pfe_pkg::FN_PUSH_EVENT, pack_word(4'd0, 8'h00, 4'd0, 1'b0));
		send_op(pfe_pkg::FN_PUSH_EVENT, pack_word(4'd0, 8'hFF, 4'd0, 1'b0));
		// state 15 has no links yet: no match
		send_op(pfe_pkg::FN_PUSH_EVENT, pack_word(4'd0, 8'h12, 4'd0, 1'b0));
		// fill state 15, then one more add overflows the list
		for (int k = 0; k <= MAX_LK; k++)
			send_op(pfe_pkg::FN_ADD_LINK, pack_word(4'd15, 8'(k), 4'(k), 1'b0));
		// match on the last link: longest scan
		send_op(pfe_pkg::FN_PUSH_EVENT, pack_word(4'd0, 8'(MAX_LK - 1), 4'd0, 1'b0));
		send_op(pfe_pkg::FN_SET_STATE, pack_word(4'd15, 8'h00, 4'd0, 1'b0));
		send_op(pfe_pkg::FN_PUSH_EVENT, pack_word(4'd0, 8'h00, 4'd0, 1'b0));
		drain();

		// Random traffic under the idle and stall profiles; each phase ends drained.
		run_phase(PHASE_LEN, 0, 0, 1'b1);
		run_phase(PHASE_LEN, 70, 0, 1'b0);
		run_phase(PHASE_LEN, 0, 70, 1'b1);
		run_phase(PHASE_LEN, 25, 25, 1'b0);

		repeat (TAIL_LEN) @(posedge clk);
		if (shadow.mismatches == 0 && shadow.expected_results.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
